[rtl/sll_pkg.sv]
`default_nettype none

package sll_pkg;

  localparam int ActionW   = 2;
  localparam int PositionW = 10;
  localparam int DataW     = 32;
  localparam int StatusW   = 2;
  localparam int LengthW   = 10;
  localparam int TdataW    = 48;

  localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionW-1:0] ACT_DELETE = 2'd1;
  localparam logic [ActionW-1:0] ACT_READ   = 2'd2;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/sll_ram.sv]
`default_nettype none

module sll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/static_linked_list_manager.sv]
`default_nettype none

// Singly linked list kept in a pool of POOL_SLOTS nodes; slots 0 and POOL_SLOTS-1 are
// reserved, so at most POOL_SLOTS-2 elements fit. Each item is insert, delete or read at a
// one-based position and gives exactly one result item with status, read value and length.
// After reset the block builds the free chain in the link memory, one slot a cycle, and
// takes no item until the chain is built. The walk to a position follows one link a cycle
// through the single read port of the link memory, and the block works on one item at a
// time, taking no new item until the last has its result. A finished result sits in an
// output register, so the next item is taken while it waits; a further result waits until
// that register is free.
module static_linked_list_manager
  import sll_pkg::*;
#(
  parameter int POOL_SLOTS  = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output      logic              s_tready,
  input  wire logic [TdataW-1:0] s_tdata,  // action[1:0], position[11:2], value[43:12]
  output      logic              m_tvalid,
  input  wire logic              m_tready,
  output      logic [TdataW-1:0] m_tdata   // status[1:0], read_value[33:2], list_length[43:34]
);

  localparam int SW   = $clog2(POOL_SLOTS);
  localparam int CMPW = ((SW > PositionW) ? SW : PositionW) + 1;
  localparam logic [SW-1:0] LastSlot = SW'(POOL_SLOTS - 1);
  localparam logic [SW-1:0] LastLink = SW'(POOL_SLOTS - 3);
  localparam logic [SW-1:0] MaxCount = SW'(POOL_SLOTS - 2);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FREE  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_WR2   = 7'b0010000,
    S_VAL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t               state;
  logic [SW-1:0]        clr;
  logic [ActionW-1:0]   op;
  logic [PositionW-1:0] pos;
  logic [DataW-1:0]     val;
  logic [SW-1:0]        cur;
  logic [SW-1:0]        prv;
  logic [PositionW-1:0] rem;
  logic [SW-1:0]        nfh;
  logic [SW-1:0]        free_head;
  logic [SW-1:0]        list_head;
  logic [SW-1:0]        count;
  logic [StatusW-1:0]   pend_status;
  logic [DataW-1:0]     pend_rd;
  logic                 out_valid;
  logic [TdataW-1:0]    out_data;

  logic [ActionW-1:0]   in_action;
  logic [PositionW-1:0] in_pos;
  logic [DataW-1:0]     in_value;
  logic [CMPW-1:0]      pos_ext;
  logic [CMPW-1:0]      cnt_ext;
  logic                 ins_ok;
  logic                 del_ok;

  logic                   link_we;
  logic [SW-1:0]          link_waddr;
  logic [SW-1:0]          link_wdata;
  logic [SW-1:0]          link_raddr;
  logic [SW-1:0]          link_rdata;
  logic                   value_we;
  logic [VALUE_WIDTH-1:0] value_wdata;
  logic [VALUE_WIDTH-1:0] value_rdata;
  logic [63:0]            val_wide;
  logic [63:0]            rd_wide;

  assign in_action = s_tdata[1:0];
  assign in_pos    = s_tdata[11:2];
  assign in_value  = s_tdata[43:12];
  assign pos_ext   = CMPW'(in_pos);
  assign cnt_ext   = CMPW'(count);
  assign ins_ok    = (in_pos != '0) && (pos_ext <= cnt_ext + CMPW'(1));
  assign del_ok    = (in_pos != '0) && (pos_ext <= cnt_ext);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign val_wide    = {32'd0, val};
  assign value_wdata = VALUE_WIDTH'(val_wide);
  assign rd_wide     = 64'(signed'(value_rdata));

  // link memory ports and value memory write enable
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = free_head;
    link_raddr = cur;
    value_we   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr;
        link_wdata = ((clr != '0) && (clr <= LastLink)) ? clr + 1'b1 : '0;
      end
      S_IDLE: begin
        link_raddr = (in_action == ACT_INSERT) ? free_head : list_head;
      end
      S_FREE: begin
        link_raddr = list_head;
        if (pos == PositionW'(1)) begin
          link_we    = 1'b1;
          link_waddr = free_head;
          link_wdata = list_head;
          value_we   = 1'b1;
        end
      end
      S_WALK: begin
        link_raddr = link_rdata;
        if (rem == '0) begin
          if (op == ACT_INSERT) begin
            link_we    = 1'b1;
            link_waddr = free_head;
            link_wdata = link_rdata;
            value_we   = 1'b1;
          end else if (op == ACT_DELETE) begin
            link_we = 1'b1;
            if (pos == PositionW'(1)) begin
              link_waddr = cur;
              link_wdata = free_head;
            end else begin
              link_waddr = prv;
              link_wdata = link_rdata;
            end
          end
        end
      end
      S_WR2: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = free_head;
      end
      S_VAL, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  sll_ram #(
    .WIDTH (SW),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  sll_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (POOL_SLOTS)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (free_head),
    .wdata (value_wdata),
    .raddr (cur),
    .rdata (value_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      free_head <= SW'(1);
      list_head <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == LastSlot) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= in_action;
            pos     <= in_pos;
            val     <= in_value;
            pend_rd <= '0;
            cur     <= list_head;
            rem     <= in_pos - PositionW'(1);
            unique case (in_action)
              ACT_INSERT: begin
                if (!ins_ok) begin
                  pend_status <= ST_RANGE;
                  state       <= S_DONE;
                end else if (free_head == '0) begin
                  pend_status <= ST_FULL;
                  state       <= S_DONE;
                end else begin
                  pend_status <= ST_OK;
                  state       <= S_FREE;
                end
              end
              ACT_DELETE, ACT_READ: begin
                if (!del_ok) begin
                  pend_status <= ST_RANGE;
                  state       <= S_DONE;
                end else begin
                  pend_status <= ST_OK;
                  state       <= S_WALK;
                end
              end
              default: begin
                pend_status <= ST_RANGE;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_FREE: begin
          nfh <= link_rdata;
          if (pos == PositionW'(1)) begin
            list_head <= free_head;
            free_head <= link_rdata;
            count     <= count + 1'b1;
            state     <= S_DONE;
          end else begin
            cur   <= list_head;
            rem   <= pos - PositionW'(2);
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (rem != '0) begin
            prv <= cur;
            cur <= link_rdata;
            rem <= rem - 1'b1;
          end else begin
            unique case (op)
              ACT_INSERT: state <= S_WR2;
              ACT_DELETE: begin
                if (pos == PositionW'(1)) begin
                  list_head <= link_rdata;
                  free_head <= cur;
                  count     <= count - 1'b1;
                  state     <= S_DONE;
                end else begin
                  state <= S_WR2;
                end
              end
              ACT_READ: state <= S_VAL;
              default:  state <= S_DONE;
            endcase
          end
        end
        S_WR2: begin
          if (op == ACT_INSERT) begin
            free_head <= nfh;
            count     <= count + 1'b1;
          end else begin
            free_head <= cur;
            count     <= count - 1'b1;
          end
          state <= S_DONE;
        end
        S_VAL: begin
          pend_rd <= rd_wide[31:0];
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {4'd0, LengthW'(count), pend_rd, pend_status};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MaxCount)
    else $error("element count beyond pool capacity");

  a_full_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |-> ((free_head == '0) == (count == MaxCount)))
    else $error("free chain and element count disagree");

  a_empty_matches_head: assert property (@(posedge clk) disable iff (rst)
    (list_head == '0) == (count == '0))
    else $error("list head and element count disagree");

  a_walk_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> ((cur != '0) && (cur != LastSlot)))
    else $error("walk reached a reserved slot");
`endif

endmodule

`default_nettype wire
